// ===== hdl/assert_macros.svh =====
// assertion helpers for the arrowhead checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is applied
`define ARW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define ARW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/arw_pkg.sv =====
`default_nettype none
package arw_pkg;

  localparam int CoordBits   = 16;
  localparam int FracBits    = 8;
  localparam int RegBits     = 15;
  localparam int RootBits    = CoordBits + 1 + FracBits;
  localparam int RemBits     = RootBits + 3;
  localparam int SqBits      = 2 * CoordBits + 2;
  localparam int QuoBits     = RegBits + 1;
  localparam int NumBits     = CoordBits + RegBits + FracBits + 1;
  localparam int SumBits     = CoordBits + 4;
  localparam int CfgAddrBits = 2;
  localparam int CfgDataBits = 16;

  localparam logic [CfgAddrBits-1:0] RegHeadLen   = CfgAddrBits'(0);
  localparam logic [CfgAddrBits-1:0] RegWingWidth = CfgAddrBits'(1);

  localparam logic [RegBits-1:0] HeadLenReset = RegBits'(10);
  localparam logic [RegBits-1:0] WingReset    = RegBits'(7);

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [CoordBits:0]   diff_t;
  typedef logic [CoordBits:0]          extent_t;

  typedef struct packed {
    coord_t                tx;
    coord_t                ty;
    coord_t                rx;
    coord_t                ry;
    diff_t                 dx;
    diff_t                 dy;
    logic [SqBits-1:0]     d2;
    logic [RootBits-1:0]   root;
    logic [RemBits-1:0]    rem;
    logic [NumBits-1:0]    nax;
    logic [NumBits-1:0]    nay;
    logic [NumBits-1:0]    ncx;
    logic [NumBits-1:0]    ncy;
    logic [QuoBits-1:0]    qax;
    logic [QuoBits-1:0]    qay;
    logic [QuoBits-1:0]    qcx;
    logic [QuoBits-1:0]    qcy;
    coord_t                lx;
    coord_t                ly;
    coord_t                qx;
    coord_t                qy;
    coord_t                bx;
    coord_t                by;
    extent_t               bw;
    extent_t               bh;
  } arw_stage_t;

endpackage
`default_nettype wire

// ===== hdl/arw_in_if.sv =====
`default_nettype none
interface arw_in_if import arw_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t tip_x;
  coord_t tip_y;
  coord_t ref_x;
  coord_t ref_y;

  modport source (output valid, tip_x, tip_y, ref_x, ref_y, input ready);
  modport sink   (input valid, tip_x, tip_y, ref_x, ref_y, output ready);
endinterface
`default_nettype wire

// ===== hdl/arw_out_if.sv =====
`default_nettype none
interface arw_out_if import arw_pkg::*; ();
  logic    valid;
  logic    ready;
  coord_t  left_x;
  coord_t  left_y;
  coord_t  right_x;
  coord_t  right_y;
  coord_t  box_x;
  coord_t  box_y;
  extent_t box_w;
  extent_t box_h;

  modport source (output valid, left_x, left_y, right_x, right_y, box_x, box_y, box_w, box_h,
                  input ready);
  modport sink   (input valid, left_x, left_y, right_x, right_y, box_x, box_y, box_w, box_h,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/arw_cfg_if.sv =====
`default_nettype none
interface arw_cfg_if import arw_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CfgAddrBits-1:0] addr;
  logic [CfgDataBits-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/arrowhead_vertex_geometry.sv =====
// arrowhead wing ends and bounding box, one arrow per clock
// pipeline: 2 prep stages, 25 root stages, 1 product stage, 16 divide stages,
//   round/saturate, bounding box
// throughput: one arrow per cycle; the whole pipe holds while the result waits
// reset: rst_ni async active low clears all stage valid bits and loads
//   head_length = 10, wing_width = 7
`default_nettype none
module arrowhead_vertex_geometry import arw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  arw_in_if.sink    in_if,
  arw_out_if.source out_if,
  arw_cfg_if.sink   cfg_if
);

  // stage map
  localparam int StDiff    = 0;
  localparam int StSq      = 1;
  localparam int StRoot    = 2;
  localparam int StMul     = StRoot + RootBits;
  localparam int StDiv     = StMul + 1;
  localparam int StRnd     = StDiv + QuoBits;
  localparam int StBox     = StRnd + 1;
  localparam int NumStages = StBox + 1;

  logic [RegBits-1:0]   head_len_q;
  logic [RegBits-1:0]   wing_q;
  logic [NumStages-1:0] vld_q;
  arw_stage_t           st_q [NumStages];
  logic                 adv;

  // ---------------------------------------------------------------------------
  // configuration registers, always ready; unknown indexes are dropped
  // ---------------------------------------------------------------------------
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_len_q <= HeadLenReset;
      wing_q     <= WingReset;
    end else if (cfg_if.valid) begin
      case (cfg_if.addr)
        RegHeadLen:   head_len_q <= cfg_if.data[RegBits-1:0];
        RegWingWidth: wing_q     <= cfg_if.data[RegBits-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: the pipe moves whenever the output slot is free or drains
  // ---------------------------------------------------------------------------
  assign adv         = !vld_q[NumStages-1] || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_if.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // helpers for the round stage
  // ---------------------------------------------------------------------------

  // round(k - k*L*2^F/D), nearest with ties away from zero; q, r from |k|*L*2^F / D
  function automatic logic signed [SumBits-1:0] along_f(
    diff_t k, logic [QuoBits-1:0] q, logic [NumBits-1:0] r, logic [RootBits-1:0] den);
    logic signed [SumBits-1:0] kk;
    logic signed [SumBits-1:0] qq;
    logic signed [SumBits-1:0] n;
    logic [NumBits:0]          r2;
    logic [NumBits:0]          dd;
    logic                      up;
    kk = SumBits'(k);
    qq = $signed(SumBits'(q));
    r2 = {r, 1'b0};
    dd = (NumBits+1)'(den);
    if (!k[CoordBits]) begin
      // value is n + (D-r)/D
      n  = kk - qq - SumBits'(1);
      up = (r2 < dd) || ((r2 == dd) && !n[SumBits-1]);
    end else begin
      // value is n + r/D
      n  = kk + qq;
      up = (r2 > dd) || ((r2 == dd) && !n[SumBits-1]);
    end
    return up ? n + SumBits'(1) : n;
  endfunction

  // round(k*W*2^F / 2D) from the magnitude quotient; tie goes away from zero
  function automatic logic signed [SumBits-1:0] across_f(
    diff_t k, logic [QuoBits-1:0] q, logic [NumBits-1:0] r, logic [RootBits-1:0] den);
    logic signed [SumBits-1:0] mag;
    mag = $signed(SumBits'(q)) + ((r >= NumBits'(den)) ? SumBits'(1) : SumBits'(0));
    return k[CoordBits] ? -mag : mag;
  endfunction

  function automatic coord_t sat_f(logic signed [SumBits-1:0] v);
    logic signed [SumBits-1:0] hi;
    logic signed [SumBits-1:0] lo;
    hi = SumBits'({1'b0, {(CoordBits-1){1'b1}}});
    lo = -hi - SumBits'(1);
    if (v > hi) return coord_t'(hi);
    if (v < lo) return coord_t'(lo);
    return coord_t'(v);
  endfunction

  function automatic logic [CoordBits-1:0] mag_f(diff_t v);
    diff_t a;
    a = v[CoordBits] ? -v : v;
    return a[CoordBits-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // pipeline stages
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < NumStages; k++) begin : g_st
    arw_stage_t nxt;

    if (k == StDiff) begin : g_diff
      // capture points and form the exact differences
      always_comb begin
        nxt    = '0;
        nxt.tx = in_if.tip_x;
        nxt.ty = in_if.tip_y;
        nxt.rx = in_if.ref_x;
        nxt.ry = in_if.ref_y;
        nxt.dx = diff_t'(in_if.tip_x) - diff_t'(in_if.ref_x);
        nxt.dy = diff_t'(in_if.tip_y) - diff_t'(in_if.ref_y);
      end
    end else if (k == StSq) begin : g_sq
      // squared distance
      always_comb begin
        logic signed [2*CoordBits+1:0] px;
        logic signed [2*CoordBits+1:0] py;
        nxt    = st_q[k-1];
        px     = st_q[k-1].dx * st_q[k-1].dx;
        py     = st_q[k-1].dy * st_q[k-1].dy;
        nxt.d2 = SqBits'(px) + SqBits'(py);
      end
    end else if (k < StMul) begin : g_root
      // one root digit per stage, restoring form
      localparam int I = CoordBits - (k - StRoot);
      logic [1:0] pair;
      if (I >= 0) begin : g_pair
        assign pair = st_q[k-1].d2[2*I+1:2*I];
      end else begin : g_frac
        assign pair = 2'b00;
      end
      always_comb begin
        logic [RemBits-1:0] rem_n;
        logic [RemBits-1:0] trial;
        nxt   = st_q[k-1];
        rem_n = {st_q[k-1].rem[RemBits-3:0], pair};
        trial = {1'b0, st_q[k-1].root, 2'b01};
        if (rem_n >= trial) begin
          nxt.rem  = rem_n - trial;
          nxt.root = {st_q[k-1].root[RootBits-2:0], 1'b1};
        end else begin
          nxt.rem  = rem_n;
          nxt.root = {st_q[k-1].root[RootBits-2:0], 1'b0};
        end
      end
    end else if (k == StMul) begin : g_mul
      // magnitude dividends for the four divides
      always_comb begin
        logic [RegBits+FracBits-1:0] ls;
        logic [RegBits+FracBits-1:0] ws;
        logic [CoordBits-1:0]        mx;
        logic [CoordBits-1:0]        my;
        nxt     = st_q[k-1];
        ls      = {head_len_q, {FracBits{1'b0}}};
        ws      = {wing_q, {FracBits{1'b0}}};
        mx      = mag_f(st_q[k-1].dx);
        my      = mag_f(st_q[k-1].dy);
        nxt.nax = NumBits'(mx) * NumBits'(ls);
        nxt.nay = NumBits'(my) * NumBits'(ls);
        nxt.ncx = NumBits'(mx) * NumBits'(ws);
        nxt.ncy = NumBits'(my) * NumBits'(ws);
        nxt.qax = '0;
        nxt.qay = '0;
        nxt.qcx = '0;
        nxt.qcy = '0;
      end
    end else if (k < StRnd) begin : g_div
      // one quotient bit per stage: along divides by D, across by 2D
      localparam int B = QuoBits - 1 - (k - StDiv);
      always_comb begin
        logic [NumBits-1:0] dva;
        logic [NumBits:0]   dvc;
        nxt = st_q[k-1];
        dva = NumBits'(st_q[k-1].root) << B;
        dvc = (NumBits+1)'(st_q[k-1].root) << (B + 1);
        if (st_q[k-1].nax >= dva) begin
          nxt.nax    = st_q[k-1].nax - dva;
          nxt.qax[B] = 1'b1;
        end
        if (st_q[k-1].nay >= dva) begin
          nxt.nay    = st_q[k-1].nay - dva;
          nxt.qay[B] = 1'b1;
        end
        if ({1'b0, st_q[k-1].ncx} >= dvc) begin
          nxt.ncx    = st_q[k-1].ncx - dvc[NumBits-1:0];
          nxt.qcx[B] = 1'b1;
        end
        if ({1'b0, st_q[k-1].ncy} >= dvc) begin
          nxt.ncy    = st_q[k-1].ncy - dvc[NumBits-1:0];
          nxt.qcy[B] = 1'b1;
        end
      end
    end else if (k == StRnd) begin : g_rnd
      // round, place the wing ends, saturate
      always_comb begin
        logic signed [SumBits-1:0] cdl1;
        logic signed [SumBits-1:0] sdl1;
        logic signed [SumBits-1:0] cl2;
        logic signed [SumBits-1:0] sl2;
        logic signed [SumBits-1:0] bxs;
        logic signed [SumBits-1:0] bys;
        nxt = st_q[k-1];
        if (st_q[k-1].root == '0) begin
          // coincident points: direction taken as (1,0)
          cdl1 = -$signed(SumBits'(head_len_q));
          sdl1 = '0;
          cl2  = $signed(SumBits'((RegBits+1)'(wing_q) + (RegBits+1)'(1)) >>> 1);
          sl2  = '0;
        end else begin
          cdl1 = along_f(st_q[k-1].dx, st_q[k-1].qax, st_q[k-1].nax, st_q[k-1].root);
          sdl1 = along_f(st_q[k-1].dy, st_q[k-1].qay, st_q[k-1].nay, st_q[k-1].root);
          cl2  = across_f(st_q[k-1].dx, st_q[k-1].qcx, st_q[k-1].ncx, st_q[k-1].root);
          sl2  = across_f(st_q[k-1].dy, st_q[k-1].qcy, st_q[k-1].ncy, st_q[k-1].root);
        end
        bxs    = SumBits'(st_q[k-1].rx) + cdl1;
        bys    = SumBits'(st_q[k-1].ry) + sdl1;
        nxt.lx = sat_f(bxs - sl2);
        nxt.ly = sat_f(bys + cl2);
        nxt.qx = sat_f(bxs + sl2);
        nxt.qy = sat_f(bys - cl2);
      end
    end else begin : g_box
      // bounding box of tip and wing ends; this stage is the output register
      always_comb begin
        coord_t                  x0;
        coord_t                  x1;
        coord_t                  y0;
        coord_t                  y1;
        logic signed [CoordBits+1:0] ex;
        logic signed [CoordBits+1:0] ey;
        nxt = st_q[k-1];
        x0  = st_q[k-1].tx;
        x1  = st_q[k-1].tx;
        y0  = st_q[k-1].ty;
        y1  = st_q[k-1].ty;
        if (st_q[k-1].lx < x0) x0 = st_q[k-1].lx;
        if (st_q[k-1].qx < x0) x0 = st_q[k-1].qx;
        if (st_q[k-1].lx > x1) x1 = st_q[k-1].lx;
        if (st_q[k-1].qx > x1) x1 = st_q[k-1].qx;
        if (st_q[k-1].ly < y0) y0 = st_q[k-1].ly;
        if (st_q[k-1].qy < y0) y0 = st_q[k-1].qy;
        if (st_q[k-1].ly > y1) y1 = st_q[k-1].ly;
        if (st_q[k-1].qy > y1) y1 = st_q[k-1].qy;
        ex     = (CoordBits+2)'(x1) - (CoordBits+2)'(x0) + (CoordBits+2)'(1);
        ey     = (CoordBits+2)'(y1) - (CoordBits+2)'(y0) + (CoordBits+2)'(1);
        nxt.bx = x0;
        nxt.by = y0;
        nxt.bw = ex[CoordBits:0];
        nxt.bh = ey[CoordBits:0];
      end
    end

    // payload registers carry no reset
    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result transfer
  // ---------------------------------------------------------------------------
  assign out_if.valid   = vld_q[NumStages-1];
  assign out_if.left_x  = st_q[StBox].lx;
  assign out_if.left_y  = st_q[StBox].ly;
  assign out_if.right_x = st_q[StBox].qx;
  assign out_if.right_y = st_q[StBox].qy;
  assign out_if.box_x   = st_q[StBox].bx;
  assign out_if.box_y   = st_q[StBox].by;
  assign out_if.box_w   = st_q[StBox].bw;
  assign out_if.box_h   = st_q[StBox].bh;

endmodule
`default_nettype wire

// ===== hdl/arw_chk.sv =====
`default_nettype none
`include "assert_macros.svh"
module arw_chk import arw_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input coord_t  left_x,
  input coord_t  right_x,
  input coord_t  box_x,
  input extent_t box_w
);

  `ARW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `ARW_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable({left_x, box_w}), "result moved")
  `ARW_ASSERT(a_in_stall, !in_ready |-> out_valid && !out_ready, "input held without stall")
  `ARW_ASSERT(a_box_x, out_valid |-> box_x <= left_x && box_x <= right_x, "box past a wing")
  `ARW_ASSERT(a_box_w, out_valid |-> box_w != '0, "empty box width")

endmodule

bind arrowhead_vertex_geometry arw_chk u_arw_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .left_x    (out_if.left_x),
  .right_x   (out_if.right_x),
  .box_x     (out_if.box_x),
  .box_w     (out_if.box_w)
);
`default_nettype wire
